/* hw/rtl/sfd_pkg.sv */
// ----------------------------------------------------------------------------
// sfd_pkg: shared types and constants of the six-axis serial frame decoder
// Frame lead bytes, frame lengths, button remap table and the control word
// between the sequencer and the nibble unit.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int BUFFER_DEPTH_DEF = 64;

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_MOTION = 8'h64;   // 'd'
    localparam logic [7:0] CH_KEYS   = 8'h6B;   // 'k'

    localparam int MOTION_LEN   = 26;
    localparam int KEYS_LEN_MIN = 5;
    localparam int KEYS_LEN_MAX = 7;

    // nibbles of a motion frame: six axes of four
    localparam int NIB_COUNT = 24;
    localparam int ACC_W     = 4 * NIB_COUNT;
    localparam int AXIS_W    = 16;
    localparam int MAP_W     = 48;
    localparam int KNIB_W    = 3;

    localparam logic KIND_MOTION = 1'b0;
    localparam logic KIND_KEYS   = 1'b1;

    localparam int MAP_LEN = 19;
    localparam logic [5:0] BTN_MAP [MAP_LEN] = '{
        6'd12, 6'd13, 6'd14, 6'd15, 6'd22, 6'd25, 6'd23, 6'd24, 6'd0, 6'd1,
        6'd2, 6'd4, 6'd5, 6'd8, 6'd26, 6'd3, 6'd6, 6'd7, 6'd9
    };

    typedef struct packed {
        logic              shift;      // shift one nibble into the accumulator
        logic [KNIB_W-1:0] key_nibs;   // data nibbles of a button frame
    } t_unit_ctl;

endpackage

/* hw/rtl/sfd_nib_unit.sv */
// ----------------------------------------------------------------------------
// sfd_nib_unit: shared nibble accumulator
// Collects frame nibbles one per cycle while shift is set in a shift register
// and forms the six axis words and the remapped button word from it.
// ----------------------------------------------------------------------------
module sfd_nib_unit
    import sfd_pkg::*;
(
    input  logic              i_clk,
    input  t_unit_ctl         i_ctl,
    input  logic [3:0]        i_nib,
    output logic [AXIS_W-1:0] o_axis0,
    output logic [AXIS_W-1:0] o_axis1,
    output logic [AXIS_W-1:0] o_axis2,
    output logic [AXIS_W-1:0] o_axis3,
    output logic [AXIS_W-1:0] o_axis4,
    output logic [AXIS_W-1:0] o_axis5,
    output logic [MAP_W-1:0]  o_keys
);

    logic [ACC_W-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_acc <= {r_acc[ACC_W-5:0], i_nib};
        end
    end

    // first nibble ends up most significant; bit 15 flip removes the offset
    assign o_axis0 = r_acc[ACC_W-1    -: AXIS_W] ^ 16'h8000;
    assign o_axis1 = r_acc[ACC_W-17   -: AXIS_W] ^ 16'h8000;
    assign o_axis2 = r_acc[ACC_W-33   -: AXIS_W] ^ 16'h8000;
    assign o_axis3 = r_acc[ACC_W-49   -: AXIS_W] ^ 16'h8000;
    assign o_axis4 = r_acc[ACC_W-65   -: AXIS_W] ^ 16'h8000;
    assign o_axis5 = r_acc[ACC_W-81   -: AXIS_W] ^ 16'h8000;

    // button nibble j sits at r_acc[ACC_W-1-4j -: 4], LSB first in raw order
    always_comb begin
        o_keys = '0;
        for (int i = 0; i < MAP_LEN; i++) begin
            if ((KNIB_W'(i >> 2) < i_ctl.key_nibs) &&
                r_acc[ACC_W - 4 - 4 * (i >> 2) + (i & 3)]) begin
                o_keys[BTN_MAP[i]] = 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/six_axis_serial_frame_decoder_core.sv */
// ----------------------------------------------------------------------------
// six_axis_serial_frame_decoder_core: serial six-axis frame decoder
// Stores received bytes in a ring, and on a carriage return decodes a motion
// ('d') or button ('k') frame into one report word.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+---------------------------
//  rx       | in        | i_in_valid / o_in_stall    | i_rx_byte
//  report   | out       | o_out_valid / i_out_stall  | o_report_kind, six axes,
//           |           |                            | o_button_map
//
//  Ordinary bytes are written to the ring and the block is ready again at
//  once. A carriage return is written, then entries 0..24 are read through
//  the single read port of the ring (S_READ), the registered read data drains
//  (S_DRAIN) and the report register is loaded (S_DONE); new bytes stall meanwhile.
//  Reset (i_rst_n low, synchronous) clears the ring index, the sequencer and
//  the report valid; ring contents are not cleared.
//  A report waiting in the output register does not block new bytes; only a
//  second finished report waits in the last state until the first is taken.
// ----------------------------------------------------------------------------
module six_axis_serial_frame_decoder_core
    import sfd_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // rx byte channel
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [7:0]               i_rx_byte,
    // report channel
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_report_kind,
    output logic signed [AXIS_W-1:0] o_trans_x,
    output logic signed [AXIS_W-1:0] o_trans_y,
    output logic signed [AXIS_W-1:0] o_trans_z,
    output logic signed [AXIS_W-1:0] o_rot_x,
    output logic signed [AXIS_W-1:0] o_rot_y,
    output logic signed [AXIS_W-1:0] o_rot_z,
    output logic [MAP_W-1:0]         o_button_map
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    // ring and index
    logic [7:0]    r_ring [BUFFER_DEPTH];
    logic [AW-1:0] r_idx;
    logic [AW-1:0] n_idx;
    logic [AW-1:0] idx_inc;

    // sequencer
    t_state        r_state;
    t_state        n_state;
    logic [AW-1:0] r_len;        // wrapped index after the carriage return
    logic [AW-1:0] r_addr;       // read address
    logic [7:0]    r_rd_data;
    logic          r_rd_vld;
    logic          r_rd_first;   // read data is entry 0, the lead byte
    logic [7:0]    r_lead;

    // report register
    logic              r_out_vld;
    logic              r_out_kind;
    logic [AXIS_W-1:0] r_tx, r_ty, r_tz, r_rx, r_ry, r_rz;
    logic [MAP_W-1:0]  r_map;

    logic in_acc;
    logic out_acc;
    logic motion_ok;
    logic keys_ok;
    logic load;

    t_unit_ctl         unit_ctl;
    logic [AXIS_W-1:0] ax0, ax1, ax2, ax3, ax4, ax5;
    logic [MAP_W-1:0]  keys;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_acc    = r_out_vld && !i_out_stall;

    assign idx_inc = (r_idx == AW'(BUFFER_DEPTH - 1)) ? '0 : r_idx + AW'(1);

    // frame checks on the captured lead byte and the wrapped length
    assign motion_ok = (r_lead == CH_MOTION) && (r_len == AW'(MOTION_LEN));
    assign keys_ok   = (r_lead == CH_KEYS) &&
                       (r_len >= AW'(KEYS_LEN_MIN)) && (r_len <= AW'(KEYS_LEN_MAX));

    // a good frame loads when the report register is free or draining
    assign load = (r_state == S_DONE) && (motion_ok || keys_ok) &&
                  (!r_out_vld || !i_out_stall);

    // ring write and registered read
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ring[r_idx] <= i_rx_byte;
        end
        r_rd_data <= r_ring[r_addr];
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_idx = (i_rx_byte == CH_CR) ? '0 : idx_inc;
                    if (i_rx_byte == CH_CR) begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                if (r_addr == AW'(NIB_COUNT)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!(motion_ok || keys_ok) || load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_idx      <= '0;
            r_addr     <= '0;
            r_rd_vld   <= 1'b0;
            r_rd_first <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_rd_vld   <= (r_state == S_READ);
            r_rd_first <= (r_state == S_READ) && (r_addr == '0);
            if (r_state == S_READ) begin
                r_addr <= r_addr + AW'(1);
            end else begin
                r_addr <= '0;
            end
            if (load) begin
                r_out_vld <= 1'b1;
            end else if (out_acc) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_rx_byte == CH_CR)) begin
            r_len <= idx_inc;
        end
        if (r_rd_vld && r_rd_first) begin
            r_lead <= r_rd_data;
        end
        if (load) begin
            r_out_kind <= motion_ok ? KIND_MOTION : KIND_KEYS;
            r_tx       <= motion_ok ? ax0 : '0;
            r_ty       <= motion_ok ? ax1 : '0;
            r_tz       <= motion_ok ? ax2 : '0;
            r_rx       <= motion_ok ? ax4 : '0;
            r_ry       <= motion_ok ? (AXIS_W'(0) - ax3) : '0;
            r_rz       <= motion_ok ? (AXIS_W'(0) - ax5) : '0;
            r_map      <= motion_ok ? '0 : keys;
        end
    end

    // entries 1..24 shift in as nibbles; entry 0 is the lead byte
    assign unit_ctl.shift    = r_rd_vld && !r_rd_first;
    assign unit_ctl.key_nibs = KNIB_W'(r_len - AW'(2));

    sfd_nib_unit u_nib (
        .i_clk   (i_clk),
        .i_ctl   (unit_ctl),
        .i_nib   (r_rd_data[3:0]),
        .o_axis0 (ax0),
        .o_axis1 (ax1),
        .o_axis2 (ax2),
        .o_axis3 (ax3),
        .o_axis4 (ax4),
        .o_axis5 (ax5),
        .o_keys  (keys)
    );

    assign o_out_valid   = r_out_vld;
    assign o_report_kind = r_out_kind;
    assign o_trans_x     = $signed(r_tx);
    assign o_trans_y     = $signed(r_ty);
    assign o_trans_z     = $signed(r_tz);
    assign o_rot_x       = $signed(r_rx);
    assign o_rot_y       = $signed(r_ry);
    assign o_rot_z       = $signed(r_rz);
    assign o_button_map  = r_map;

    // a carriage return always starts a decode pass
    a_cr_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_rx_byte == CH_CR)) |=> (r_state == S_READ))
        else $error("carriage return did not start decode");

    // the index is back at zero for the whole decode pass
    a_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_idx == '0))
        else $error("ring index not cleared during decode");

    // a report is only loaded from the final state
    a_load_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> ($past(r_state) == S_DONE))
        else $error("report loaded outside final state");

    // read address stops one past the last motion nibble
    a_addr_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_addr <= AW'(NIB_COUNT + 1))
        else $error("read address out of range");

endmodule
